### rtl/rida_pkg.sv
// Shared types and constants for the RGB image distance accumulator.
// No dependencies; imported by every module of the block.
`default_nettype none

package rida_pkg;

	localparam int CHANNEL_BITS  = 8;
	localparam int FRACTION_BITS = 8;
	localparam int MAX_PIXELS    = 65536;

	localparam int SUM_W    = 33;
	localparam int CNT_W    = 17;
	localparam int THRESH_W = 17;
	localparam int RATIO_FRAC_BITS = 16;

	// sum of three squared channel differences
	localparam int SQ_W   = 2 * CHANNEL_BITS + 2;
	localparam int ROOT_W = SQ_W / 2 + FRACTION_BITS;
	localparam int SREM_W = ROOT_W + 2;

	// square root: fixed number of digit steps per cycle
	localparam int SQRT_STEPS  = 4;
	localparam int SQRT_CYCLES = (ROOT_W + SQRT_STEPS - 1) / SQRT_STEPS;
	localparam int RAD_W       = 2 * SQRT_STEPS * SQRT_CYCLES;

	localparam int DIV_BITS = SUM_W;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
	localparam logic [CNT_W-1:0] CNT_LIMIT =
		(MAX_PIXELS > ((1 << CNT_W) - 1)) ? CNT_MAX : CNT_W'(MAX_PIXELS);
	localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

	// metric_mode codes
	localparam logic [1:0] MODE_TOTAL    = 2'd0;
	localparam logic [1:0] MODE_MEAN     = 2'd1;
	localparam logic [1:0] MODE_FRACTION = 2'd2;

	// register indexes
	localparam logic REG_MODE   = 1'b0;
	localparam logic REG_THRESH = 1'b1;

	typedef struct packed {
		logic            last;
		logic [SQ_W-1:0] sq;
	} pair_t;

	typedef struct packed {
		logic [1:0]          mode;
		logic [THRESH_W-1:0] threshold;
	} cfg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROOT,
		ST_ACCUM,
		ST_SETUP,
		ST_DIV,
		ST_EMIT
	} back_state_t;

endpackage

`default_nettype wire

### rtl/rgb_image_distance_accumulator.sv
// RGB image distance accumulator: top level with the register port.
// Depends on rida_pkg, rida_front, rida_queue and rida_back.
//
// Usage: pixel pairs enter on the s_* stream, one pair of 8-bit RGB pixels
// per word, with s_tlast on the final pair of an image. Each pair yields
// the Euclidean RGB distance (8 fraction bits), which is accumulated. On the
// last pair one word leaves on m_*: total, mean or fraction over threshold,
// as set by metric_mode, with the pixel count and the saturation flag; the
// accumulators then clear.
// The pair rate is set by the square root unit (four digit steps a cycle)
// plus the pop and accumulate states; the back takes no new pair before it
// has accumulated the last one. A last pair then goes through the setup
// state, the serial divider in the mean and fraction modes, and the emit
// state into the output register. A four-word queue lets the front keep
// taking pairs while the back is busy. Registers must be written only while
// the block is idle; the block itself does not enforce it. Reset clears the
// accumulators, the queue and both registers. When the receiver stalls, the
// result word holds in the output register and the back stops only once a
// second result is ready; input stalls then follow.
`default_nettype none

module rgb_image_distance_accumulator
	import rida_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	// s_tdata: own_red, own_green, own_blue, other_red, other_green, other_blue
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [47:0] s_tdata,
	input  wire logic        s_tlast,
	// m_tdata: result_value[32:0], pixels_seen[49:33], zero pad[55:50]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [55:0]      m_tdata,
	// m_tuser: count_overflowed
	output logic             m_tuser,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	cfg_t             cfg_q;
	logic             cfg_write;
	logic             push, q_full, q_valid, pop;
	pair_t            push_data, q_head;
	logic [SUM_W-1:0] out_value;
	logic [CNT_W-1:0] out_pixels;
	logic             out_overflow;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode      <= MODE_TOTAL;
			cfg_q.threshold <= '0;
		end else if (cfg_write) begin
			unique case (paddr[2])
				REG_MODE:   cfg_q.mode      <= pwdata[1:0];
				REG_THRESH: cfg_q.threshold <= pwdata[THRESH_W-1:0];
				default:    ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_MODE:   prdata = 32'(cfg_q.mode);
			REG_THRESH: prdata = 32'(cfg_q.threshold);
			default:    prdata = '0;
		endcase
	end

	rida_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.own_red     (s_tdata[7:0]),
		.own_green   (s_tdata[15:8]),
		.own_blue    (s_tdata[23:16]),
		.other_red   (s_tdata[31:24]),
		.other_green (s_tdata[39:32]),
		.other_blue  (s_tdata[47:40]),
		.last_pixel  (s_tlast),
		.push        (push),
		.push_data   (push_data),
		.q_full      (q_full)
	);

	rida_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.valid     (q_valid),
		.head      (q_head),
		.pop       (pop)
	);

	rida_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.q_valid      (q_valid),
		.q_head       (q_head),
		.pop          (pop),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.out_value    (out_value),
		.out_pixels   (out_pixels),
		.out_overflow (out_overflow)
	);

	assign m_tdata = {6'b0, out_pixels, out_value};
	assign m_tuser = out_overflow;

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_full) else $error("queue written while full");

	a_pop_needs_data: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> q_valid) else $error("queue read while empty");

	a_count_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[49:33] <= CNT_LIMIT))
		else $error("pixel count above limit");

endmodule

`default_nettype wire

### rtl/rida_front.sv
// Front end: accepts pixel pairs and forms the squared RGB distance.
// Depends on rida_pkg; feeds rida_queue.
`default_nettype none

module rida_front
	import rida_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	output logic                         in_ready,
	input  wire logic [CHANNEL_BITS-1:0] own_red,
	input  wire logic [CHANNEL_BITS-1:0] own_green,
	input  wire logic [CHANNEL_BITS-1:0] own_blue,
	input  wire logic [CHANNEL_BITS-1:0] other_red,
	input  wire logic [CHANNEL_BITS-1:0] other_green,
	input  wire logic [CHANNEL_BITS-1:0] other_blue,
	input  wire logic                    last_pixel,
	output logic                         push,
	output pair_t                        push_data,
	input  wire logic                    q_full
);

	logic                    valid_s1;
	pair_t                   pair_s1;
	logic [CHANNEL_BITS-1:0] dr, dg, db;
	logic [SQ_W-1:0]         sq;

	always_comb begin
		dr = (own_red   >= other_red)   ? own_red - other_red     : other_red - own_red;
		dg = (own_green >= other_green) ? own_green - other_green : other_green - own_green;
		db = (own_blue  >= other_blue)  ? own_blue - other_blue   : other_blue - own_blue;
		sq = SQ_W'(dr * dr) + SQ_W'(dg * dg) + SQ_W'(db * db);
	end

	assign push      = valid_s1 && !q_full;
	assign push_data = pair_s1;
	assign in_ready  = !valid_s1 || !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			pair_s1.sq   <= sq;
			pair_s1.last <= last_pixel;
		end
	end

endmodule

`default_nettype wire

### rtl/rida_queue.sv
// Short FIFO of squared distances between the front and back ends.
// Depends on rida_pkg.
`default_nettype none

module rida_queue
	import rida_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  pair_t     push_data,
	output logic      full,
	output logic      valid,
	output pair_t     head,
	input  wire logic pop
);

	pair_t             entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign valid = (count_q != '0);
	assign head  = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

### rtl/rida_back.sv
// Back end: iterative square root, accumulators, serial divider and the
// output register. Depends on rida_pkg; drains rida_queue.
`default_nettype none

module rida_back
	import rida_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  cfg_t                   cfg,
	input  wire logic              q_valid,
	input  pair_t                  q_head,
	output logic                   pop,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [SUM_W-1:0]       out_value,
	output logic [CNT_W-1:0]       out_pixels,
	output logic                   out_overflow
);

	back_state_t state_q, state_d;

	logic [RAD_W-1:0]  rad_q;
	logic [ROOT_W-1:0] root_q;
	logic [SREM_W-1:0] srem_q;
	logic [2:0]        step_q;
	logic              last_q;

	logic [SUM_W-1:0]  sum_q;
	logic [CNT_W-1:0]  ovr_q;
	logic [CNT_W-1:0]  pix_q;
	logic              ovf_q;

	logic [SUM_W-1:0]  quo_q;
	logic [CNT_W-1:0]  drem_q;
	logic [CNT_W-1:0]  den_q;
	logic [5:0]        bit_q;
	logic [CNT_W-1:0]  res_pix_q;
	logic              res_ovf_q;

	logic              out_valid_q;
	logic              out_free;
	logic              load_out;
	logic              needs_div;

	logic [ROOT_W-1:0] root_d;
	logic [SREM_W-1:0] srem_d;
	logic [SUM_W:0]    sum_ext;
	logic [CNT_W:0]    drem_sh;
	logic              div_ge;

	assign out_free  = !out_valid_q || out_ready;
	assign needs_div = ((cfg.mode == MODE_MEAN) || (cfg.mode == MODE_FRACTION)) &&
		(pix_q != '0);

	// SQRT_STEPS digit steps of the restoring square root per cycle
	always_comb begin
		logic [SREM_W+1:0] rem_sh;
		logic [SREM_W+1:0] trial;
		root_d = root_q;
		srem_d = srem_q;
		for (int k = 0; k < SQRT_STEPS; k++) begin
			rem_sh = {srem_d, rad_q[RAD_W-1-2*k -: 2]};
			trial  = (SREM_W + 2)'({root_d, 2'b01});
			if (rem_sh >= trial) begin
				srem_d = SREM_W'(rem_sh - trial);
				root_d = {root_d[ROOT_W-2:0], 1'b1};
			end else begin
				srem_d = SREM_W'(rem_sh);
				root_d = {root_d[ROOT_W-2:0], 1'b0};
			end
		end
	end

	always_comb begin
		sum_ext = {1'b0, sum_q} + (SUM_W + 1)'(root_q);
		drem_sh = {drem_q, quo_q[SUM_W-1]};
		div_ge  = (drem_sh >= {1'b0, den_q});
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (q_valid) state_d = ST_ROOT;
			ST_ROOT:  if (step_q == 3'(SQRT_CYCLES - 1)) state_d = ST_ACCUM;
			ST_ACCUM: state_d = last_q ? ST_SETUP : ST_IDLE;
			ST_SETUP: state_d = needs_div ? ST_DIV : ST_EMIT;
			ST_DIV:   if (bit_q == 6'(DIV_BITS - 1)) state_d = ST_EMIT;
			ST_EMIT:  if (out_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		pop      = (state_q == ST_IDLE) && q_valid;
		load_out = (state_q == ST_EMIT) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			sum_q       <= '0;
			ovr_q       <= '0;
			pix_q       <= '0;
			ovf_q       <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == ST_ACCUM) begin
				if (pix_q >= CNT_LIMIT) begin
					ovf_q <= 1'b1;
				end else begin
					pix_q <= pix_q + 1'b1;
					sum_q <= sum_ext[SUM_W] ? SUM_MAX : sum_ext[SUM_W-1:0];
					if ((root_q > cfg.threshold) && (ovr_q < CNT_MAX)) begin
						ovr_q <= ovr_q + 1'b1;
					end
				end
			end else if (state_q == ST_SETUP) begin
				sum_q <= '0;
				ovr_q <= '0;
				pix_q <= '0;
				ovf_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				rad_q  <= RAD_W'({q_head.sq, {(2 * FRACTION_BITS){1'b0}}});
				root_q <= '0;
				srem_q <= '0;
				step_q <= '0;
				last_q <= q_head.last;
			end
			ST_ROOT: begin
				rad_q  <= rad_q << (2 * SQRT_STEPS);
				root_q <= root_d;
				srem_q <= srem_d;
				step_q <= step_q + 1'b1;
			end
			ST_SETUP: begin
				res_pix_q <= pix_q;
				res_ovf_q <= ovf_q;
				den_q     <= pix_q;
				drem_q    <= '0;
				bit_q     <= '0;
				if (cfg.mode == MODE_TOTAL) begin
					quo_q <= sum_q;
				end else if (cfg.mode == MODE_MEAN && pix_q != '0) begin
					quo_q <= sum_q;
				end else if (cfg.mode == MODE_FRACTION && pix_q != '0) begin
					quo_q <= SUM_W'({ovr_q, {RATIO_FRAC_BITS{1'b0}}});
				end else begin
					quo_q <= '0;
				end
			end
			ST_DIV: begin
				drem_q <= div_ge ? CNT_W'(drem_sh - {1'b0, den_q}) : drem_sh[CNT_W-1:0];
				quo_q  <= {quo_q[SUM_W-2:0], div_ge};
				bit_q  <= bit_q + 1'b1;
			end
			default: begin
			end
		endcase
		if (load_out) begin
			out_value    <= quo_q;
			out_pixels   <= res_pix_q;
			out_overflow <= res_ovf_q;
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

### tb/rgb_image_distance_accumulator_tb.sv
// Self-checking testbench for rgb_image_distance_accumulator: directed and random
// pixel-pair streams, idle bursts on both sides in the random phases, checked against an in-bench predictor.
// Depends on rida_pkg and the RTL of the block; nothing else.

module rgb_image_distance_accumulator_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import rida_pkg::*;

	localparam int         CLK_PERIOD   = 20;
	localparam int         HOLD_CYCLES  = 64;
	localparam longint     CYCLE_LIMIT  = 3_000_000;
	localparam int         RANDOM_ITEMS = 1700;
	localparam int         MAX_THRESH   = 113070;
	localparam logic [1:0] MODE_UNUSED  = 2'd3;

	typedef struct packed {
		logic       last;
		logic [7:0] other_blue;
		logic [7:0] other_green;
		logic [7:0] other_red;
		logic [7:0] own_blue;
		logic [7:0] own_green;
		logic [7:0] own_red;
	} pixel_pair_t;

	typedef struct packed {
		logic [SUM_W-1:0] value;
		logic [CNT_W-1:0] pixels;
		logic             overflowed;
	} image_result_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	// s_tdata: own_red, own_green, own_blue, other_red, other_green, other_blue
	logic [47:0] s_tdata  = '0;
	logic        s_tlast  = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	// m_tdata: result_value[32:0], pixels_seen[49:33], zero pad[55:50]
	logic [55:0] m_tdata;
	// m_tuser: count_overflowed
	logic        m_tuser;
	logic        psel     = 1'b0;
	logic        penable  = 1'b0;
	logic        pwrite   = 1'b0;
	logic [2:0]  paddr    = '0;
	logic [31:0] pwdata   = '0;
	logic [31:0] prdata;
	logic        pready;

	rgb_image_distance_accumulator dut (.*);

	pixel_pair_t   pixels_to_send[$];
	image_result_t results_due[$];

	// predictor state and its copy of the registers
	longint     acc_sum   = 0;
	longint     acc_over  = 0;
	longint     acc_count = 0;
	bit         acc_sat   = 0;
	logic [1:0] cfg_mode  = MODE_TOTAL;
	longint     cfg_thresh = 0;

	int     mismatches = 0;
	bit     idle_on    = 0;
	int     src_gap    = 0;
	int     snk_gap    = 0;
	longint cycles     = 0;
	image_result_t got, want;

	initial begin
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	function automatic longint pair_distance(pixel_pair_t p);
		longint dr, dg, db, target, root, trial;
		dr = p.own_red   > p.other_red   ? p.own_red   - p.other_red   : p.other_red   - p.own_red;
		dg = p.own_green > p.other_green ? p.own_green - p.other_green : p.other_green - p.own_green;
		db = p.own_blue  > p.other_blue  ? p.own_blue  - p.other_blue  : p.other_blue  - p.own_blue;
		target = (dr * dr + dg * dg + db * db) << (2 * FRACTION_BITS);
		root = 0;
		// floor of the square root, one result bit at a time
		for (int b = 17; b >= 0; b--) begin
			trial = root | (longint'(1) << b);
			if (trial * trial <= target)
				root = trial;
		end
		return root;
	endfunction

	task automatic account_pair(pixel_pair_t p);
		longint        pair_dist;
		image_result_t r;
		pair_dist = pair_distance(p);
		if (acc_count >= CNT_LIMIT) begin
			acc_sat = 1;
		end else begin
			acc_count++;
			acc_sum = (acc_sum + pair_dist > SUM_MAX) ? SUM_MAX : acc_sum + pair_dist;
			if (pair_dist > cfg_thresh && acc_over < CNT_MAX)
				acc_over++;
		end
		if (p.last) begin
			case (cfg_mode)
				MODE_TOTAL:    r.value = acc_sum;
				MODE_MEAN:     r.value = acc_count != 0 ? acc_sum / acc_count : 0;
				MODE_FRACTION: r.value = acc_count != 0 ?
					(acc_over << RATIO_FRAC_BITS) / acc_count : 0;
				default:       r.value = '0;
			endcase
			r.pixels     = acc_count;
			r.overflowed = acc_sat;
			results_due.push_back(r);
			acc_sum   = 0;
			acc_over  = 0;
			acc_count = 0;
			acc_sat   = 0;
		end
	endtask

	task automatic note_mismatch(string what);
		if (mismatches < 10)
			$display("mismatch: %s", what);
		mismatches++;
	endtask

	// source side: one word per handshake, idle bursts when enabled
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			src_gap  <= 0;
		end else if (!s_tvalid || s_tready) begin
			if (src_gap != 0) begin
				src_gap  <= src_gap - 1;
				s_tvalid <= 1'b0;
			end else if (idle_on && $urandom_range(0, 15) == 0) begin
				src_gap  <= $urandom_range(0, 18);
				s_tvalid <= 1'b0;
			end else if (pixels_to_send.size() != 0) begin
				pixel_pair_t p;
				p = pixels_to_send.pop_front();
				s_tdata  <= p[47:0];
				s_tlast  <= p.last;
				s_tvalid <= 1'b1;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready)
			account_pair(pixel_pair_t'({s_tlast, s_tdata}));
	end

	// sink side
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			snk_gap  <= 0;
		end else if (snk_gap != 0) begin
			snk_gap  <= snk_gap - 1;
			m_tready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 15) == 0) begin
			snk_gap  <= $urandom_range(0, 18);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got.value      = m_tdata[SUM_W-1:0];
			got.pixels     = m_tdata[SUM_W+CNT_W-1:SUM_W];
			got.overflowed = m_tuser;
			if (results_due.size() == 0) begin
				note_mismatch($sformatf("unexpected word value %0d pixels %0d overflow %0b",
					got.value, got.pixels, got.overflowed));
			end else begin
				want = results_due.pop_front();
				if (got !== want)
					note_mismatch($sformatf({"value exp %0d got %0d, pixels exp %0d got %0d, ",
						"overflow exp %0b got %0b"}, want.value, got.value, want.pixels,
						got.pixels, want.overflowed, got.overflowed));
			end
		end
	end

	task automatic reg_write(input logic idx, input logic [31:0] value);
		logic [31:0] readback;
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		if (idx == REG_MODE)
			cfg_mode = value[1:0];
		else
			cfg_thresh = value[THRESH_W-1:0];
		@(posedge clk);
		psel   <= 1'b1;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		readback = prdata;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		if (readback !== value)
			note_mismatch($sformatf("register %0d read %0d, wrote %0d", idx, readback, value));
	endtask

	task automatic set_config(input logic [1:0] mode, input longint thresh);
		reg_write(REG_MODE, 32'(mode));
		reg_write(REG_THRESH, 32'(thresh));
	endtask

	// block is idle once every word went in and every result came out
	task automatic wait_idle();
		do @(posedge clk);
		while (pixels_to_send.size() != 0 || s_tvalid || results_due.size() != 0);
		repeat (HOLD_CYCLES) @(posedge clk);
	endtask

	function automatic pixel_pair_t pair_of(input logic [7:0] r0, g0, b0, r1, g1, b1,
			input logic last);
		pixel_pair_t p;
		p = '{last, b1, g1, r1, b0, g0, r0};
		return p;
	endfunction

	function automatic pixel_pair_t random_pair(input logic last);
		pixel_pair_t p;
		int          kind;
		kind = $urandom_range(0, 7);
		p = pixel_pair_t'({last, 48'($urandom()) << 16 | 48'($urandom_range(0, 65535))});
		p[47:16] = $urandom();
		if (kind == 0) begin
			// identical pixels
			{p.other_red, p.other_green, p.other_blue} = {p.own_red, p.own_green, p.own_blue};
		end else if (kind == 1) begin
			// channels at the extremes
			p[47:0] = '0;
			for (int c = 0; c < 6; c++)
				if ($urandom_range(0, 1))
					p[8*c +: 8] = 8'hff;
		end
		return p;
	endfunction

	task automatic queue_image(input int len);
		for (int i = 0; i < len; i++)
			pixels_to_send.push_back(random_pair(i == len - 1));
	endtask

	function automatic int image_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 5)
			return 1;
		if (r < 75)
			return $urandom_range(1, 20);
		return $urandom_range(21, 120);
	endfunction

	initial begin
		int          sent, len, nimg, pick;
		logic [1:0]  mode;
		longint      thr, top_dist;
		pixel_pair_t far_pair;

		far_pair = pair_of(8'h00, 8'h00, 8'h00, 8'hff, 8'hff, 8'hff, 1'b0);
		top_dist = pair_distance(far_pair);
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// directed: extremes, each mode, threshold edges, one-pixel image
		set_config(MODE_TOTAL, 0);
		pixels_to_send.push_back(far_pair);
		pixels_to_send.push_back(pair_of(8'hff, 8'hff, 8'hff, 8'h00, 8'h00, 8'h00, 1'b0));
		pixels_to_send.push_back(pair_of(8'd17, 8'd99, 8'd200, 8'd17, 8'd99, 8'd200, 1'b0));
		pixels_to_send.push_back(pair_of(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hff, 1'b1));
		wait_idle();
		set_config(MODE_MEAN, MAX_THRESH);
		pixels_to_send.push_back(far_pair);
		pixels_to_send.push_back(pair_of(8'd1, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1));
		wait_idle();
		// distance equal to the threshold is not counted, one above is
		set_config(MODE_FRACTION, top_dist);
		pixels_to_send.push_back(far_pair);
		pixels_to_send.push_back(pair_of(8'd3, 8'd4, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1));
		wait_idle();
		set_config(MODE_FRACTION, top_dist - 1);
		pixels_to_send.push_back(far_pair);
		pixels_to_send.push_back(pair_of(8'd3, 8'd4, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0));
		pixels_to_send.push_back(pair_of(8'd9, 8'd9, 8'd9, 8'd9, 8'd9, 8'd9, 1'b1));
		wait_idle();
		set_config(MODE_FRACTION, 1280);
		pixels_to_send.push_back(pair_of(8'd3, 8'd4, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0));
		pixels_to_send.push_back(pair_of(8'd0, 8'd0, 8'd0, 8'd3, 8'd4, 8'd1, 1'b1));
		pixels_to_send.push_back(pair_of(8'd5, 8'd5, 8'd5, 8'd5, 8'd5, 8'd5, 1'b1));
		wait_idle();
		set_config(MODE_UNUSED, 0);
		pixels_to_send.push_back(far_pair);
		pixels_to_send.push_back(pair_of(8'hff, 8'h00, 8'hff, 8'h00, 8'hff, 8'h00, 1'b1));
		wait_idle();

		// random phases with idle bursts on both sides
		idle_on = 1;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			pick = $urandom_range(0, 9);
			mode = (pick == 9) ? MODE_UNUSED : 2'(pick % 3);
			case ($urandom_range(0, 5))
				0:       thr = 0;
				1:       thr = MAX_THRESH;
				2:       thr = $urandom_range(0, MAX_THRESH);
				default: thr = $urandom_range(0, 30000);
			endcase
			set_config(mode, thr);
			nimg = $urandom_range(2, 6);
			for (int i = 0; i < nimg; i++) begin
				len = image_length();
				queue_image(len);
				sent += len;
			end
			wait_idle();
		end

		// last part runs at full rate: one long image, then short ones to see
		// that the accumulators cleared
		idle_on = 0;
		set_config(MODE_FRACTION, 0);
		queue_image(40);
		wait_idle();
		set_config(MODE_MEAN, $urandom_range(0, MAX_THRESH));
		queue_image(5);
		queue_image(1);
		wait_idle();

		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

### files.f
rtl/rida_pkg.sv
rtl/rida_front.sv
rtl/rida_queue.sv
rtl/rida_back.sv
rtl/rgb_image_distance_accumulator.sv
tb/rgb_image_distance_accumulator_tb.sv
